@@ src/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and constants shared by the bump shade pixel core: item layouts,
// field widths and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

	localparam int NORM_W       = 16;
	localparam int CHAN_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int FRAC_BITS_DEF = 14;

	localparam logic [CHAN_W-1:0]  DEFAULT_CHAN_RST = 8'hFF;
	localparam logic [NORM_W-1:0]  NULL_NORMAL_RST  = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LIGHT_X       = 3'd0,
		REG_LIGHT_Y       = 3'd1,
		REG_LIGHT_Z       = 3'd2,
		REG_DEFAULT_RED   = 3'd3,
		REG_DEFAULT_GREEN = 3'd4,
		REG_DEFAULT_BLUE  = 3'd5,
		REG_NULL_NORMAL   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic [CHAN_W-1:0]        pix_red;
		logic [CHAN_W-1:0]        pix_green;
		logic [CHAN_W-1:0]        pix_blue;
		logic                     has_color;
	} pixel_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} pixel_out_t;

endpackage

`default_nettype wire

@@ src/bump_shade_pixel_core.sv @@
// ----------------------------------------------------------------------------
// bump_shade_pixel_core
// Lambertian shading, one pixel per clock unless stalled: dot product
// of surface normal and light vector scales pixel color, rounded, clamped.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid / in_ready / in_data    item into the core
//  out       out_valid / out_ready / out_data item out of the core
//  cfg       cfg_we / cfg_index / cfg_wdata   register write, no wait
//
//  Four register stages: products, dot sum and magnitude, channel products,
//  round and clamp. One item per cycle sustained while out_ready is high.
//  Each stage advances when the stage after it is empty or advancing, so a
//  stall at out_ready backs up without loss and bubbles are filled.
//  Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module bump_shade_pixel_core #(
	parameter int FRAC_BITS = bsp_pkg::FRAC_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire bsp_pkg::pixel_in_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output bsp_pkg::pixel_out_t                  out_data,
	input  wire logic                            cfg_we,
	input  wire logic [bsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bsp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	import bsp_pkg::*;

	localparam int PP_W   = 2 * NORM_W;
	localparam int DOT_W  = PP_W + 2;
	localparam int MAG_W  = DOT_W - 1;
	localparam int PROD_W = MAG_W + CHAN_W;
	localparam int SH     = 2 * FRAC_BITS;
	localparam int SUM_W  = ((PROD_W > SH) ? PROD_W : SH) + 1;
	localparam logic [SUM_W-1:0] HALF = {{(SUM_W-1){1'b0}}, 1'b1} << (SH - 1);
	localparam logic [SUM_W-1:0] MAX_CHAN = SUM_W'(255);

	logic signed [NORM_W-1:0] light_x_q, light_y_q, light_z_q;
	logic [CHAN_W-1:0]        def_red_q, def_green_q, def_blue_q;
	logic [NORM_W-1:0]        null_normal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_x_q     <= '0;
			light_y_q     <= '0;
			light_z_q     <= '0;
			def_red_q     <= DEFAULT_CHAN_RST;
			def_green_q   <= DEFAULT_CHAN_RST;
			def_blue_q    <= DEFAULT_CHAN_RST;
			null_normal_q <= NULL_NORMAL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LIGHT_X:       light_x_q     <= cfg_wdata;
				REG_LIGHT_Y:       light_y_q     <= cfg_wdata;
				REG_LIGHT_Z:       light_z_q     <= cfg_wdata;
				REG_DEFAULT_RED:   def_red_q     <= cfg_wdata[CHAN_W-1:0];
				REG_DEFAULT_GREEN: def_green_q   <= cfg_wdata[CHAN_W-1:0];
				REG_DEFAULT_BLUE:  def_blue_q    <= cfg_wdata[CHAN_W-1:0];
				REG_NULL_NORMAL:   null_normal_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits and advance chain
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: per-axis products, null test, base color
	logic                    is_null;
	logic                    color_zero;
	logic [2:0][CHAN_W-1:0]  base_in;

	always_comb begin
		is_null = (in_data.normal_x == null_normal_q) ||
		          (in_data.normal_y == null_normal_q) ||
		          (in_data.normal_z == null_normal_q);
		color_zero = (in_data.pix_red == '0) && (in_data.pix_green == '0) &&
		             (in_data.pix_blue == '0);
		if (is_null) begin
			base_in = in_data.has_color ?
			          {in_data.pix_blue, in_data.pix_green, in_data.pix_red} : '0;
		end else if (!in_data.has_color || color_zero) begin
			base_in = {def_blue_q, def_green_q, def_red_q};
		end else begin
			base_in = {in_data.pix_blue, in_data.pix_green, in_data.pix_red};
		end
	end

	logic signed [PP_W-1:0] pp_s1 [3];
	logic                   null_s1;
	logic [2:0][CHAN_W-1:0] base_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			pp_s1[0] <= $signed(in_data.normal_x) * light_x_q;
			pp_s1[1] <= $signed(in_data.normal_y) * light_y_q;
			pp_s1[2] <= $signed(in_data.normal_z) * light_z_q;
			null_s1  <= is_null;
			base_s1  <= base_in;
		end
	end

	// stage 2: dot sum, sign and magnitude
	logic signed [DOT_W-1:0] dot;
	assign dot = DOT_W'(pp_s1[0]) + DOT_W'(pp_s1[1]) + DOT_W'(pp_s1[2]);

	logic [MAG_W-1:0]       mag_s2;
	logic                   neg_s2;
	logic                   null_s2;
	logic [2:0][CHAN_W-1:0] base_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			neg_s2  <= dot[DOT_W-1];
			mag_s2  <= dot[DOT_W-1] ? MAG_W'(-dot) : MAG_W'(dot);
			null_s2 <= null_s1;
			base_s2 <= base_s1;
		end
	end

	// stage 3: scale each channel
	logic [PROD_W-1:0]      prod_s3 [3];
	logic                   neg_s3;
	logic                   null_s3;
	logic [2:0][CHAN_W-1:0] base_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int c = 0; c < 3; c++) begin
				prod_s3[c] <= mag_s2 * base_s2[c];
			end
			neg_s3  <= neg_s2;
			null_s3 <= null_s2;
			base_s3 <= base_s2;
		end
	end

	// stage 4: round half away from zero, clamp to 1..255; null passes base
	logic [2:0][CHAN_W-1:0] shade;
	logic [SUM_W-1:0]       rsum [3];
	logic [SUM_W-1:0]       q [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rsum[c] = SUM_W'(prod_s3[c]) + HALF;
			q[c]    = rsum[c] >> SH;
			if (null_s3) begin
				shade[c] = base_s3[c];
			end else if (neg_s3 || q[c] == '0) begin
				shade[c] = CHAN_W'(1);
			end else if (q[c] > MAX_CHAN) begin
				shade[c] = '1;
			end else begin
				shade[c] = q[c][CHAN_W-1:0];
			end
		end
	end

	pixel_out_t out_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			out_s4.out_red   <= shade[0];
			out_s4.out_green <= shade[1];
			out_s4.out_blue  <= shade[2];
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = out_s4;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty first stage");

	a_shaded_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && adv4 && !null_s3 |=> out_data.out_red != '0 &&
		out_data.out_green != '0 && out_data.out_blue != '0)
		else $error("shaded pixel has a zero channel");

	a_neg_gives_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && adv4 && !null_s3 && neg_s3 |=> out_data.out_red == CHAN_W'(1) &&
		out_data.out_green == CHAN_W'(1) && out_data.out_blue == CHAN_W'(1))
		else $error("negative shade not floored to one");

	a_stage_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && adv3 |=> valid_s4)
		else $error("item dropped between stages three and four");

endmodule

`default_nettype wire

@@ tb/sv/bump_shade_pixel_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_shade_pixel_core_tb
// Self-checking bench for the bump shade pixel core. A scoreboard predicts
// each shaded pixel from its own copy of the light, default color and null
// registers. Directed pixels cover the rounding, clamping, default color and
// null cases, then random phases run with different register settings
// while the sender and the receiver idle at various rates.
// ----------------------------------------------------------------------------

module bump_shade_pixel_core_tb;

	import bsp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE      = 8;
	localparam int SHIFT       = 2 * FRAC_BITS_DEF;

	class pixel_shade_board;
		logic signed [NORM_W-1:0] light_x, light_y, light_z;
		logic [CHAN_W-1:0]        def_red, def_green, def_blue;
		logic [NORM_W-1:0]        null_val;
		pixel_out_t               shaded_q[$];
		int                       errors;

		function new();
			light_x   = '0;
			light_y   = '0;
			light_z   = '0;
			def_red   = DEFAULT_CHAN_RST;
			def_green = DEFAULT_CHAN_RST;
			def_blue  = DEFAULT_CHAN_RST;
			null_val  = NULL_NORMAL_RST;
			errors    = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_LIGHT_X:       light_x   = val;
				REG_LIGHT_Y:       light_y   = val;
				REG_LIGHT_Z:       light_z   = val;
				REG_DEFAULT_RED:   def_red   = val[CHAN_W-1:0];
				REG_DEFAULT_GREEN: def_green = val[CHAN_W-1:0];
				REG_DEFAULT_BLUE:  def_blue  = val[CHAN_W-1:0];
				REG_NULL_NORMAL:   null_val  = val;
				default: ;
			endcase
		endfunction

		function logic [CHAN_W-1:0] shade_chan(longint dot, logic [CHAN_W-1:0] base);
			longint mag;
			longint q;
			mag = (dot < 0) ? -dot : dot;
			q = (mag * longint'(base) + (longint'(1) << (SHIFT - 1))) >>> SHIFT;
			if (dot < 0 || q == 0)
				return 8'd1;
			if (q > 255)
				return 8'd255;
			return q[CHAN_W-1:0];
		endfunction

		function void note_pixel(pixel_in_t px);
			pixel_out_t        res;
			logic [CHAN_W-1:0] br, bg, bb;
			longint            dot;
			if (px.normal_x == null_val || px.normal_y == null_val
					|| px.normal_z == null_val) begin
				res.out_red   = px.has_color ? px.pix_red   : 8'd0;
				res.out_green = px.has_color ? px.pix_green : 8'd0;
				res.out_blue  = px.has_color ? px.pix_blue  : 8'd0;
			end else begin
				br = px.pix_red;
				bg = px.pix_green;
				bb = px.pix_blue;
				if (!px.has_color || {br, bg, bb} == '0) begin
					br = def_red;
					bg = def_green;
					bb = def_blue;
				end
				dot = longint'(px.normal_x) * longint'(light_x)
					+ longint'(px.normal_y) * longint'(light_y)
					+ longint'(px.normal_z) * longint'(light_z);
				res.out_red   = shade_chan(dot, br);
				res.out_green = shade_chan(dot, bg);
				res.out_blue  = shade_chan(dot, bb);
			end
			shaded_q = {shaded_q, res};
		endfunction

		function void check_pixel(pixel_out_t got);
			pixel_out_t want;
			string      chan_name[3];
			chan_name = '{"blue", "green", "red"};
			if (shaded_q.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = shaded_q.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (got[CHAN_W*i +: CHAN_W] !== want[CHAN_W*i +: CHAN_W]) begin
					$display("%0t: out_%s expected %0d actual %0d", $time, chan_name[i],
						want[CHAN_W*i +: CHAN_W], got[CHAN_W*i +: CHAN_W]);
					errors++;
				end
			end
		endfunction

		function int pending();
			return shaded_q.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	pixel_in_t             in_data;
	logic                  out_valid;
	logic                  out_ready;
	pixel_out_t            out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pixel_shade_board book;
	int               idle_pct;
	int               stall_pct;
	int               quiet_cycles;

	bump_shade_pixel_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				book.note_pixel(in_data);
			if (out_valid && out_ready)
				book.check_pixel(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic pixel_in_t make_pixel(int nx, int ny, int nz,
			int r, int g, int b, bit has);
		pixel_in_t px;
		px.normal_x    = nx[NORM_W-1:0];
		px.normal_y    = ny[NORM_W-1:0];
		px.normal_z    = nz[NORM_W-1:0];
		px.pix_red     = r[CHAN_W-1:0];
		px.pix_green   = g[CHAN_W-1:0];
		px.pix_blue    = b[CHAN_W-1:0];
		px.has_color   = has;
		return px;
	endfunction

	function automatic pixel_in_t rand_pixel(logic [NORM_W-1:0] null_v);
		logic [NORM_W-1:0] n[3];
		bit                wide;
		wide = ($urandom_range(99) < 30);
		for (int i = 0; i < 3; i++) begin
			if (wide)
				n[i] = NORM_W'($urandom);
			else
				n[i] = NORM_W'($urandom_range(32768) - 16384);
			if ($urandom_range(19) == 0)
				n[i] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		end
		if ($urandom_range(9) == 0)
			n[2'($urandom_range(2))] = null_v;
		if ($urandom_range(9) == 0)
			return make_pixel(int'(n[0]), int'(n[1]), int'(n[2]), 0, 0, 0,
				1'($urandom_range(1)));
		return make_pixel(int'(n[0]), int'(n[1]), int'(n[2]), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(9) != 0);
	endfunction

	// call at a falling edge; returns at the falling edge after the item is taken
	task automatic push_pixel(input pixel_in_t px);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (book.pending() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] vals[7]);
		cfg_reg_t idx;
		for (int i = 0; i < 7; i++) begin
			idx = cfg_reg_t'(i);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= vals[idx];
			@(posedge clk);
			book.set_reg(idx, vals[idx]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] setup[7];
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_ready    = 1'b1;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_wdata    = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		quiet_cycles = 0;
		book         = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: dark light, null at the most negative code
		push_pixel(make_pixel(-32768, 0, 0, 5, 6, 7, 1));
		push_pixel(make_pixel(100, 200, 300, 9, 9, 9, 0));
		drain_pixels();

		setup[REG_LIGHT_X]       = 16'd0;
		setup[REG_LIGHT_Y]       = 16'd0;
		setup[REG_LIGHT_Z]       = 16'd16384;
		setup[REG_DEFAULT_RED]   = 16'd255;
		setup[REG_DEFAULT_GREEN] = 16'd128;
		setup[REG_DEFAULT_BLUE]  = 16'd0;
		setup[REG_NULL_NORMAL]   = 16'h8000;
		program_regs(setup);
		push_pixel(make_pixel(0, 0, 16384, 200, 100, 50, 1));
		push_pixel(make_pixel(0, 0, -16384, 200, 100, 50, 1));
		push_pixel(make_pixel(0, 0, 32767, 255, 255, 255, 1));
		push_pixel(make_pixel(0, 0, 0, 200, 100, 50, 1));
		push_pixel(make_pixel(0, 0, 16384, 200, 100, 50, 0));
		push_pixel(make_pixel(0, 0, 16384, 0, 0, 0, 1));
		push_pixel(make_pixel(-32768, 0, 0, 10, 20, 30, 1));
		push_pixel(make_pixel(0, -32768, 0, 0, 0, 0, 1));
		push_pixel(make_pixel(0, 0, -32768, 10, 20, 30, 0));
		push_pixel(make_pixel(0, 0, 8192, 3, 1, 2, 1));
		push_pixel(make_pixel(0, 0, 8191, 3, 255, 2, 1));
		push_pixel(make_pixel(1, 1, 1, 0, 0, 1, 1));
		push_pixel(make_pixel(32767, 32767, 16384, 255, 0, 255, 1));
		drain_pixels();

		setup[REG_LIGHT_X]       = 16'h8000;
		setup[REG_LIGHT_Y]       = 16'h8000;
		setup[REG_LIGHT_Z]       = 16'h8000;
		setup[REG_DEFAULT_RED]   = 16'd255;
		setup[REG_DEFAULT_GREEN] = 16'd0;
		setup[REG_DEFAULT_BLUE]  = 16'd128;
		setup[REG_NULL_NORMAL]   = 16'h7FFF;
		program_regs(setup);
		push_pixel(make_pixel(-32768, -32768, -32768, 1, 0, 200, 1));
		push_pixel(make_pixel(16384, 0, 0, 1, 2, 3, 0));
		push_pixel(make_pixel(32767, 0, 0, 9, 8, 7, 1));
		push_pixel(make_pixel(0, 32767, 0, 9, 8, 7, 0));
		push_pixel(make_pixel(-1, -1, -1, 0, 0, 0, 1));
		push_pixel(make_pixel(16'h5555, 16'hAAAA, 16'h5555, 8'hAA, 8'h55, 8'hAA, 1));
		drain_pixels();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 18; stall_pct = 18; end
			endcase
			if (p == 0) begin
				setup[REG_LIGHT_X]       = 16'h7FFF;
				setup[REG_LIGHT_Y]       = 16'h7FFF;
				setup[REG_LIGHT_Z]       = 16'h7FFF;
				setup[REG_DEFAULT_RED]   = 16'd0;
				setup[REG_DEFAULT_GREEN] = 16'd0;
				setup[REG_DEFAULT_BLUE]  = 16'd0;
				setup[REG_NULL_NORMAL]   = 16'd0;
			end else if (p == 1) begin
				setup[REG_LIGHT_X]       = 16'h8000;
				setup[REG_LIGHT_Y]       = 16'h8000;
				setup[REG_LIGHT_Z]       = 16'h8000;
				setup[REG_DEFAULT_RED]   = 16'd255;
				setup[REG_DEFAULT_GREEN] = 16'd255;
				setup[REG_DEFAULT_BLUE]  = 16'd255;
				setup[REG_NULL_NORMAL]   = 16'h7FFF;
			end else begin
				setup[REG_LIGHT_X] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
					: CFG_DATA_W'($urandom_range(32768) - 16384);
				setup[REG_LIGHT_Y] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
					: CFG_DATA_W'($urandom_range(32768) - 16384);
				setup[REG_LIGHT_Z] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
					: CFG_DATA_W'($urandom_range(32768) - 16384);
				setup[REG_DEFAULT_RED]   = CFG_DATA_W'($urandom_range(255));
				setup[REG_DEFAULT_GREEN] = CFG_DATA_W'($urandom_range(255));
				setup[REG_DEFAULT_BLUE]  = CFG_DATA_W'($urandom_range(255));
				setup[REG_NULL_NORMAL]   = CFG_DATA_W'($urandom);
			end
			program_regs(setup);
			for (int k = 0; k < 200; k++)
				push_pixel(rand_pixel(book.null_val));
			drain_pixels();
		end

		if (book.errors == 0 && book.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
